@@ hdl/neighborhood_filter_3x3_unit_assert.svh @@
// ----------------------------------------------------------------------------
// neighborhood filter assertion macros
// shared property forms used by the filter modules
// ----------------------------------------------------------------------------
`ifndef NEIGHBORHOOD_FILTER_3X3_UNIT_ASSERT_SVH
`define NEIGHBORHOOD_FILTER_3X3_UNIT_ASSERT_SVH

// same-cycle implication
`define NF3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/nf3_pkg.sv @@
// ----------------------------------------------------------------------------
// nf3_pkg
// types and constants of the 3x3 neighborhood filter
// ----------------------------------------------------------------------------
package nf3_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int Q_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

    localparam logic [2:0] MODE_BOX    = 3'd0;
    localparam logic [2:0] MODE_SOBEL  = 3'd1;
    localparam logic [2:0] MODE_MEDIAN = 3'd2;
    localparam logic [2:0] MODE_MIN    = 3'd3;
    localparam logic [2:0] MODE_MAX    = 3'd4;

    // ceil(2^16 / 9), exact floor division for sums up to 2299
    localparam logic [12:0] BOX_RECIP = 13'd7282;

    typedef struct packed {
        logic [8:0][PIX_W-1:0] pix;
        logic                  frame_end;
    } t_win_item;

endpackage

@@ hdl/nf3_if.sv @@
// ----------------------------------------------------------------------------
// nf3 channel interfaces
// pixel input, filtered output and register write channels
// ----------------------------------------------------------------------------
interface nf3_pix_in_if;
    import nf3_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             drain;
    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

interface nf3_pix_out_if;
    import nf3_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface nf3_cfg_if;
    import nf3_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/nf3_ram.sv @@
// ----------------------------------------------------------------------------
// nf3_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module nf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/nf3_front.sv @@
// ----------------------------------------------------------------------------
// nf3_front
// takes pixels, runs the row stores and window, queues each output window
// ----------------------------------------------------------------------------
module nf3_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    nf3_pix_in_if.sink                         i_pix,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]    i_height,
    input  logic                               i_full,
    output logic                               o_push,
    output nf3_pkg::t_win_item                 o_item
);
    import nf3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = $clog2(MAX_HEIGHT);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_UPD  = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;
    logic [PIX_W-1:0] r_pix;
    logic             r_drain;
    logic [CW-1:0]    r_in_col;
    logic [RW-1:0]    r_in_row;
    logic [CW-1:0]    r_out_col;
    logic [ORW-1:0]   r_out_row;
    logic [2:0][2:0][PIX_W-1:0] r_win, n_win, win;

    logic [PIX_W-1:0] up_rd, mid_rd, pix_v;
    logic [2:0][PIX_W-1:0] tap;
    logic emit, go, in_last, col_last, row_last;

    nf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (go),
        .i_waddr (r_in_col),
        .i_wdata (mid_rd),
        .i_raddr (r_in_col),
        .o_rdata (up_rd)
    );

    nf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_middle (
        .i_clk   (i_clk),
        .i_we    (go),
        .i_waddr (r_in_col),
        .i_wdata (pix_v),
        .i_raddr (r_in_col),
        .o_rdata (mid_rd)
    );

    assign i_pix.ready = (r_state == F_IDLE);

    always_comb begin
        pix_v = (r_drain || (32'(r_in_row) >= 32'(i_height))) ? '0 : r_pix;
        emit  = (32'(r_in_row) >= 32'd2) || ((r_in_row == RW'(1)) && (r_in_col != '0));
        in_last  = (32'(r_in_col) + 32'd1) >= 32'(i_width);
        col_last = (32'(r_out_col) + 32'd1) >= 32'(i_width);
        row_last = (32'(r_out_row) + 32'd1) >= 32'(i_height);
        tap[0] = up_rd;
        tap[1] = mid_rd;
        tap[2] = pix_v;

        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
            n_win[k][2] = tap[k];
        end

        // column 0 closes the previous row, window seen before the shift
        win = r_win;
        if (r_in_col == '0) begin
            for (int k = 0; k < 3; k++) begin
                win[k][0] = r_win[k][1];
                win[k][1] = r_win[k][2];
                win[k][2] = r_win[k][2];
            end
        end else begin
            win = n_win;
            if (col_last) begin
                for (int k = 0; k < 3; k++) begin
                    win[k][2] = win[k][1];
                end
            end
        end
        // replicate clamping at the borders
        if (r_out_col == '0) begin
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
            end
        end
        if (r_out_row == '0) begin
            win[0] = win[1];
        end
        if (row_last) begin
            win[2] = win[1];
        end

        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                o_item.pix[k*3+j] = win[k][j];
            end
        end
        o_item.frame_end = row_last && col_last;

        go     = (r_state == F_UPD) && (!emit || !i_full);
        o_push = go && emit;

        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_pix.valid) begin
                    n_state = F_READ;
                end
            end
            F_READ: n_state = F_UPD;
            F_UPD: begin
                if (go) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE) begin
            r_pix   <= i_pix.pixel_in;
            r_drain <= i_pix.drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_win     <= '0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_win <= n_win;
                if (in_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
                if (emit) begin
                    if (row_last && col_last) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                    end else if (col_last) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ORW'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end
endmodule

@@ hdl/nf3_queue.sv @@
// ----------------------------------------------------------------------------
// nf3_queue
// short window queue between front and back
// ----------------------------------------------------------------------------
module nf3_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nf3_pkg::t_win_item i_item,
    input  logic               i_pop,
    output nf3_pkg::t_win_item o_item,
    output logic               o_full,
    output logic               o_empty
);
    import nf3_pkg::*;
    `include "neighborhood_filter_3x3_unit_assert.svh"

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int NW = $clog2(Q_DEPTH + 1);

    t_win_item     r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == NW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == Q_DEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == Q_DEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    `NF3_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, 32'(r_cnt) <= Q_DEPTH, "queue overfilled")
    `NF3_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `NF3_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `NF3_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + NW'(1),
        "queue count lost a push")
endmodule

@@ hdl/nf3_back.sv @@
// ----------------------------------------------------------------------------
// nf3_back
// runs the selected filter on one window and holds the result
// ----------------------------------------------------------------------------
module nf3_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_mode,
    input  nf3_pkg::t_win_item i_item,
    input  logic               i_empty,
    output logic               o_pop,
    nf3_pix_out_if.source      o_pix
);
    import nf3_pkg::*;
    `include "neighborhood_filter_3x3_unit_assert.svh"

    typedef enum logic [8:0] {
        B_IDLE = 9'b000000001,
        B_SUM  = 9'b000000010,
        B_DIV  = 9'b000000100,
        B_GRAD = 9'b000001000,
        B_SQ1  = 9'b000010000,
        B_SQ2  = 9'b000100000,
        B_SQRT = 9'b001000000,
        B_SORT = 9'b010000000,
        B_PICK = 9'b100000000
    } t_bstate;

    t_bstate r_state;
    logic [8:0][PIX_W-1:0] r_p, pass_p;
    logic             r_end;
    logic [20:0]      r_acc;
    logic [9:0]       r_g1, r_g2;
    logic [7:0]       r_root, try_root, new_root;
    logic [3:0]       r_cnt;
    logic             r_ovalid, r_oend;
    logic [PIX_W-1:0] r_odata;
    logic [11:0]      sum9;
    logic [10:0]      ga, gb, gc, gd;
    logic [24:0]      box_prod;

    assign o_pop           = (r_state == B_IDLE) && !i_empty && !r_ovalid;
    assign o_pix.valid     = r_ovalid;
    assign o_pix.pixel_out = r_odata;
    assign o_pix.frame_end = r_oend;

    always_comb begin
        sum9 = '0;
        for (int k = 0; k < 9; k++) begin
            sum9 = sum9 + 12'(r_p[k]);
        end
        ga = 11'(r_p[0]) + {2'b0, r_p[1], 1'b0} + 11'(r_p[2]);
        gb = 11'(r_p[6]) + {2'b0, r_p[7], 1'b0} + 11'(r_p[8]);
        gc = 11'(r_p[0]) + {2'b0, r_p[3], 1'b0} + 11'(r_p[6]);
        gd = 11'(r_p[2]) + {2'b0, r_p[5], 1'b0} + 11'(r_p[8]);
        box_prod = 25'(r_acc[11:0]) * 25'(BOX_RECIP);

        try_root = r_root | (8'd1 << r_cnt[2:0]);
        new_root = ((16'(try_root) * 16'(try_root)) <= r_acc[15:0] || r_acc[20:16] != '0)
                   ? try_root : r_root;

        // odd-even transposition pass
        pass_p = r_p;
        for (int k = 0; k < 4; k++) begin
            if (!r_cnt[0]) begin
                if (r_p[2*k] > r_p[2*k+1]) begin
                    pass_p[2*k]   = r_p[2*k+1];
                    pass_p[2*k+1] = r_p[2*k];
                end
            end else begin
                if (r_p[2*k+1] > r_p[2*k+2]) begin
                    pass_p[2*k+1] = r_p[2*k+2];
                    pass_p[2*k+2] = r_p[2*k+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (r_ovalid && o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_p   <= i_item.pix;
                        r_end <= i_item.frame_end;
                        r_cnt <= '0;
                        case (i_mode)
                            MODE_BOX:    r_state <= B_SUM;
                            MODE_SOBEL:  r_state <= B_GRAD;
                            MODE_MEDIAN: r_state <= B_SORT;
                            MODE_MIN:    r_state <= B_SORT;
                            MODE_MAX:    r_state <= B_SORT;
                            default: begin
                                r_ovalid <= 1'b1;
                                r_odata  <= i_item.pix[4];
                                r_oend   <= i_item.frame_end;
                            end
                        endcase
                    end
                end
                B_SUM: begin
                    r_acc   <= 21'(sum9) + 21'd4;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= box_prod[23:16];
                    r_oend   <= r_end;
                    r_state  <= B_IDLE;
                end
                B_GRAD: begin
                    r_g1    <= (ga >= gb) ? 10'(ga - gb) : 10'(gb - ga);
                    r_g2    <= (gc >= gd) ? 10'(gc - gd) : 10'(gd - gc);
                    r_state <= B_SQ1;
                end
                B_SQ1: begin
                    r_acc   <= 21'(r_g1) * 21'(r_g1);
                    r_state <= B_SQ2;
                end
                B_SQ2: begin
                    r_acc   <= r_acc + 21'(r_g2) * 21'(r_g2);
                    r_root  <= '0;
                    r_cnt   <= 4'd7;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    r_root <= new_root;
                    if (r_cnt == '0) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= new_root;
                        r_oend   <= r_end;
                        r_state  <= B_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                B_SORT: begin
                    r_p <= pass_p;
                    if (r_cnt == 4'd8) begin
                        r_state <= B_PICK;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                B_PICK: begin
                    r_ovalid <= 1'b1;
                    r_oend   <= r_end;
                    r_state  <= B_IDLE;
                    case (i_mode)
                        MODE_MIN: r_odata <= r_p[0];
                        MODE_MAX: r_odata <= r_p[8];
                        default:  r_odata <= r_p[4];
                    endcase
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `NF3_ASSERT_NOW(a_pop_out_free, i_clk, i_rst_n, o_pop, !r_ovalid, "window taken over result")
    `NF3_ASSERT_NOW(a_sort_cnt, i_clk, i_rst_n, r_state == B_SORT, r_cnt <= 4'd8,
        "sort pass count out of range")
    `NF3_ASSERT_NOW(a_sqrt_cnt, i_clk, i_rst_n, r_state == B_SQRT, r_cnt <= 4'd7,
        "root bit index out of range")
    `NF3_ASSERT_NXT(a_pick_out, i_clk, i_rst_n, r_state == B_PICK, r_ovalid,
        "sorted result not presented")
endmodule

@@ hdl/neighborhood_filter_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// neighborhood_filter_3x3_unit
// streaming 3x3 box / sobel / median / min / max filter for grey pixels
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  i_pix    in   valid/ready  pixel_in[7:0], drain
//  o_pix    out  valid/ready  pixel_out[7:0], frame_end
//  i_cfg    in   valid/ready  index[1:0], data[12:0]
//
//  front takes a pixel when idle, reads the row stores, then updates
//  back per window: box sum+div, sobel grad+sq+root, sort+pick, else centre
//  a 2-entry window queue lets front and back stall apart
//  reset is synchronous; row stores are not cleared, counters and window are
//  config writes are taken every cycle
// ----------------------------------------------------------------------------
module neighborhood_filter_3x3_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nf3_pix_in_if.sink    i_pix,
    nf3_pix_out_if.source o_pix,
    nf3_cfg_if.sink       i_cfg
);
    import nf3_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [11:0]   r_frame_width;
    logic [12:0]   r_frame_height;
    logic [2:0]    r_filter_mode;
    logic [WW-1:0] width_c;
    logic [HW-1:0] height_c;
    logic          q_push, q_pop, q_full, q_empty;
    t_win_item     q_in, q_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd640;
            r_frame_height <= 13'd480;
            r_filter_mode  <= MODE_BOX;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[11:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                CFG_FILTER_MODE:  r_filter_mode  <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // frame sizes clamped to the supported range
    always_comb begin
        if (r_frame_width < 12'd4) begin
            width_c = WW'(4);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            width_c = WW'(MAX_WIDTH);
        end else begin
            width_c = WW'(r_frame_width);
        end
        if (r_frame_height < 13'd4) begin
            height_c = HW'(4);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            height_c = HW'(MAX_HEIGHT);
        end else begin
            height_c = HW'(r_frame_height);
        end
    end

    nf3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_width  (width_c),
        .i_height (height_c),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_item   (q_in)
    );

    nf3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    nf3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_filter_mode),
        .i_item  (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_pix   (o_pix)
    );
endmodule
